@@ rtl/tmm_pkg.sv @@
// shared types, constants and helper functions of the model matrix block
`timescale 1ns / 1ps
package tmm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 30;

    localparam int ANG_W  = 34;
    localparam int D_W    = 32;
    localparam int CW     = 34;
    localparam int PW     = 2 * CW;
    localparam int SW     = 66;

    localparam longint ANG_FULL    = longint'(360) << FRAC_BITS;
    localparam longint ANG_QUARTER = longint'(90) << FRAC_BITS;
    localparam longint ANG_BIAS_N  = ((longint'(1) << 31) + ANG_FULL - 1) / ANG_FULL;
    localparam longint ANG_BIAS    = ANG_BIAS_N * ANG_FULL;
    localparam longint ANG_TOP     = (longint'(1) << 31) - 1 + ANG_BIAS;
    localparam int     RED_STEPS   = $clog2(ANG_TOP / ANG_FULL + 1);

    localparam logic [30:0]           DEG2RAD  = 31'd1199381129;
    localparam logic signed [CW-1:0]  INV_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x_deg;
        logic signed [31:0] rot_y_deg;
        logic signed [31:0] rot_z_deg;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } xform_t;

    typedef struct packed {
        logic signed [31:0] m_r0c0;
        logic signed [31:0] m_r1c0;
        logic signed [31:0] m_r2c0;
        logic signed [31:0] m_r0c1;
        logic signed [31:0] m_r1c1;
        logic signed [31:0] m_r2c1;
        logic signed [31:0] m_r0c2;
        logic signed [31:0] m_r1c2;
        logic signed [31:0] m_r2c2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } matrix_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            5'd24:   v = 34'sd63;
            5'd25:   v = 34'sd31;
            5'd26:   v = 34'sd15;
            5'd27:   v = 34'sd8;
            5'd28:   v = 34'sd4;
            5'd29:   v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round to nearest of a q60 product back to q30, half up
    function automatic logic signed [CW-1:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(64'sd536870912);
        return t[30+CW-1:30];
    endfunction

endpackage

@@ rtl/tmm_xform_if.sv @@
// request channel carrying one transform
`timescale 1ns / 1ps
interface tmm_xform_if;
    import tmm_pkg::*;
    logic   valid;
    logic   ready;
    xform_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tmm_matrix_if.sv @@
// request channel carrying one model matrix
`timescale 1ns / 1ps
interface tmm_matrix_if;
    import tmm_pkg::*;
    logic    valid;
    logic    ready;
    matrix_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/trs_model_matrix_top.sv @@
// model matrix T*Rz*Ry*Rx*S from position, euler angles and scale
`timescale 1ns / 1ps
// Accepts one transform request per cycle while the last stage is empty or its
// result is taken, and returns one matrix request per request, in order. The
// stages are the angle bias add, one compare-subtract stage per quotient bit of
// the angle reduction, two quadrant stages, the degree-to-radian multiply and
// its rounding, 30 CORDIC stages (one micro-rotation each, all three angles in
// parallel), the quadrant fold and six stages of products, rounding and
// saturation. The whole pipe holds while the result in the last stage is not
// taken; nothing is dropped or repeated.
module trs_model_matrix_top (
    input logic         clk,
    input logic         rst_n,
    tmm_xform_if.sink   xform,
    tmm_matrix_if.source matrix
);
    import tmm_pkg::*;

    localparam int ANG_STAGES = RED_STEPS + CORDIC_STEPS + 6;
    localparam int LAT        = ANG_STAGES + 6;
    localparam int S1         = ANG_STAGES;

    function automatic logic signed [31:0] sat_q(input logic signed [SW-1:0] p);
        logic signed [SW-1:0] t;
        logic signed [35:0]   v;
        t = p + SW'(64'sd536870912);
        v = t[SW-1:30];
        if (v > 36'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -36'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic                 en;
    logic                 valid_reg [LAT];
    xform_t               side_reg [LAT-1];
    logic signed [31:0]   ang [3];

    logic [ANG_W-1:0]     red_reg [3][RED_STEPS+1];
    logic [D_W-1:0]       qa_d_reg [3];
    logic                 qa_hi_reg [3];
    logic [D_W-1:0]       qb_d_reg [3];
    logic [1:0]           qb_q_reg [3];
    logic [63:0]          prod_reg [3];
    logic [1:0]           prod_q_reg [3];
    logic signed [CW-1:0] x_reg [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] z_reg [3][CORDIC_STEPS+1];
    logic [1:0]           cq_reg [3][CORDIC_STEPS+1];
    logic signed [CW-1:0] cos_reg [3];
    logic signed [CW-1:0] sin_reg [3];

    logic signed [PW-1:0] p1_reg [10];
    logic signed [CW-1:0] c1_reg [3];
    logic signed [CW-1:0] t2_reg [10];
    logic signed [CW-1:0] c2_reg [3];
    logic signed [PW-1:0] p3_reg [4];
    logic signed [CW-1:0] t3_reg [10];
    logic signed [CW-1:0] c3_reg;
    logic signed [CW-1:0] r4_reg [9];
    logic signed [SW-1:0] p5_reg [9];
    matrix_t              out_reg;

    assign en           = !valid_reg[LAT-1] || matrix.ready;
    assign xform.ready  = en;
    assign matrix.valid = valid_reg[LAT-1];
    assign matrix.data  = out_reg;

    assign ang[0] = xform.data.rot_x_deg;
    assign ang[1] = xform.data.rot_y_deg;
    assign ang[2] = xform.data.rot_z_deg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= xform.valid;
            for (int i = 1; i < LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // angle reduction, quadrant, radians and cordic per axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= xform.data;
            for (int i = 1; i < LAT - 1; i++)
                side_reg[i] <= side_reg[i-1];

            for (int a = 0; a < 3; a++)
            begin
                red_reg[a][0] <= ANG_W'(ang[a]) + ANG_W'(ANG_BIAS);
                for (int k = 0; k < RED_STEPS; k++)
                begin
                    if (red_reg[a][k] >= (ANG_W'(ANG_FULL) << (RED_STEPS - 1 - k)))
                        red_reg[a][k+1] <= red_reg[a][k]
                                           - (ANG_W'(ANG_FULL) << (RED_STEPS - 1 - k));
                    else
                        red_reg[a][k+1] <= red_reg[a][k];
                end

                if (red_reg[a][RED_STEPS] >= ANG_W'(2 * ANG_QUARTER))
                begin
                    qa_d_reg[a]  <= D_W'(red_reg[a][RED_STEPS] - ANG_W'(2 * ANG_QUARTER));
                    qa_hi_reg[a] <= 1'b1;
                end
                else
                begin
                    qa_d_reg[a]  <= D_W'(red_reg[a][RED_STEPS]);
                    qa_hi_reg[a] <= 1'b0;
                end

                if (qa_d_reg[a] >= D_W'(ANG_QUARTER))
                begin
                    qb_d_reg[a] <= qa_d_reg[a] - D_W'(ANG_QUARTER);
                    qb_q_reg[a] <= {qa_hi_reg[a], 1'b1};
                end
                else
                begin
                    qb_d_reg[a] <= qa_d_reg[a];
                    qb_q_reg[a] <= {qa_hi_reg[a], 1'b0};
                end

                prod_reg[a]   <= 64'(qb_d_reg[a]) * 64'(DEG2RAD);
                prod_q_reg[a] <= qb_q_reg[a];

                x_reg[a][0]  <= INV_GAIN;
                y_reg[a][0]  <= '0;
                z_reg[a][0]  <= CW'((prod_reg[a] + (64'd1 << (FRAC_BITS + 5)))
                                    >> (FRAC_BITS + 6));
                cq_reg[a][0] <= prod_q_reg[a];

                for (int i = 0; i < CORDIC_STEPS; i++)
                begin
                    if (!z_reg[a][i][CW-1])
                    begin
                        x_reg[a][i+1] <= x_reg[a][i] - (y_reg[a][i] >>> i);
                        y_reg[a][i+1] <= y_reg[a][i] + (x_reg[a][i] >>> i);
                        z_reg[a][i+1] <= z_reg[a][i] - atan_q30(5'(i));
                    end
                    else
                    begin
                        x_reg[a][i+1] <= x_reg[a][i] + (y_reg[a][i] >>> i);
                        y_reg[a][i+1] <= y_reg[a][i] - (x_reg[a][i] >>> i);
                        z_reg[a][i+1] <= z_reg[a][i] + atan_q30(5'(i));
                    end
                    cq_reg[a][i+1] <= cq_reg[a][i];
                end

                case (cq_reg[a][CORDIC_STEPS])
                    2'd0:
                    begin
                        cos_reg[a] <= x_reg[a][CORDIC_STEPS];
                        sin_reg[a] <= y_reg[a][CORDIC_STEPS];
                    end
                    2'd1:
                    begin
                        cos_reg[a] <= -y_reg[a][CORDIC_STEPS];
                        sin_reg[a] <= x_reg[a][CORDIC_STEPS];
                    end
                    2'd2:
                    begin
                        cos_reg[a] <= -x_reg[a][CORDIC_STEPS];
                        sin_reg[a] <= -y_reg[a][CORDIC_STEPS];
                    end
                    default:
                    begin
                        cos_reg[a] <= y_reg[a][CORDIC_STEPS];
                        sin_reg[a] <= -x_reg[a][CORDIC_STEPS];
                    end
                endcase
            end
        end
    end

    // matrix products, rounding and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= PW'(cos_reg[2]) * PW'(sin_reg[1]);
            p1_reg[1] <= PW'(sin_reg[2]) * PW'(sin_reg[1]);
            p1_reg[2] <= PW'(cos_reg[2]) * PW'(cos_reg[1]);
            p1_reg[3] <= PW'(sin_reg[2]) * PW'(cos_reg[1]);
            p1_reg[4] <= PW'(cos_reg[1]) * PW'(sin_reg[0]);
            p1_reg[5] <= PW'(cos_reg[1]) * PW'(cos_reg[0]);
            p1_reg[6] <= PW'(sin_reg[2]) * PW'(cos_reg[0]);
            p1_reg[7] <= PW'(cos_reg[2]) * PW'(cos_reg[0]);
            p1_reg[8] <= PW'(sin_reg[2]) * PW'(sin_reg[0]);
            p1_reg[9] <= PW'(cos_reg[2]) * PW'(sin_reg[0]);
            c1_reg[0] <= sin_reg[0];
            c1_reg[1] <= cos_reg[0];
            c1_reg[2] <= sin_reg[1];

            for (int j = 0; j < 10; j++)
                t2_reg[j] <= rnd30(p1_reg[j]);
            for (int j = 0; j < 3; j++)
                c2_reg[j] <= c1_reg[j];

            p3_reg[0] <= PW'(t2_reg[0]) * PW'(c2_reg[0]);
            p3_reg[1] <= PW'(t2_reg[1]) * PW'(c2_reg[0]);
            p3_reg[2] <= PW'(t2_reg[0]) * PW'(c2_reg[1]);
            p3_reg[3] <= PW'(t2_reg[1]) * PW'(c2_reg[1]);
            for (int j = 0; j < 10; j++)
                t3_reg[j] <= t2_reg[j];
            c3_reg <= c2_reg[2];

            r4_reg[0] <= t3_reg[2];
            r4_reg[1] <= t3_reg[3];
            r4_reg[2] <= -c3_reg;
            r4_reg[3] <= rnd30(p3_reg[0]) - t3_reg[6];
            r4_reg[4] <= rnd30(p3_reg[1]) + t3_reg[7];
            r4_reg[5] <= t3_reg[4];
            r4_reg[6] <= rnd30(p3_reg[2]) + t3_reg[8];
            r4_reg[7] <= rnd30(p3_reg[3]) - t3_reg[9];
            r4_reg[8] <= t3_reg[5];

            p5_reg[0] <= SW'(r4_reg[0]) * SW'(side_reg[S1+3].scale_x);
            p5_reg[1] <= SW'(r4_reg[1]) * SW'(side_reg[S1+3].scale_x);
            p5_reg[2] <= SW'(r4_reg[2]) * SW'(side_reg[S1+3].scale_x);
            p5_reg[3] <= SW'(r4_reg[3]) * SW'(side_reg[S1+3].scale_y);
            p5_reg[4] <= SW'(r4_reg[4]) * SW'(side_reg[S1+3].scale_y);
            p5_reg[5] <= SW'(r4_reg[5]) * SW'(side_reg[S1+3].scale_y);
            p5_reg[6] <= SW'(r4_reg[6]) * SW'(side_reg[S1+3].scale_z);
            p5_reg[7] <= SW'(r4_reg[7]) * SW'(side_reg[S1+3].scale_z);
            p5_reg[8] <= SW'(r4_reg[8]) * SW'(side_reg[S1+3].scale_z);

            out_reg.m_r0c0  <= sat_q(p5_reg[0]);
            out_reg.m_r1c0  <= sat_q(p5_reg[1]);
            out_reg.m_r2c0  <= sat_q(p5_reg[2]);
            out_reg.m_r0c1  <= sat_q(p5_reg[3]);
            out_reg.m_r1c1  <= sat_q(p5_reg[4]);
            out_reg.m_r2c1  <= sat_q(p5_reg[5]);
            out_reg.m_r0c2  <= sat_q(p5_reg[6]);
            out_reg.m_r1c2  <= sat_q(p5_reg[7]);
            out_reg.m_r2c2  <= sat_q(p5_reg[8]);
            out_reg.trans_x <= side_reg[LAT-2].pos_x;
            out_reg.trans_y <= side_reg[LAT-2].pos_y;
            out_reg.trans_z <= side_reg[LAT-2].pos_z;
        end
    end

endmodule

@@ test/tb_trs_model_matrix_top.sv @@
// testbench of the model matrix block: directed and random transforms against a local predictor
`timescale 1ns / 1ps
module tb_trs_model_matrix_top;
    import tmm_pkg::*;

    logic clk;
    logic rst_n;
    int   n_errors;
    int   sent_count;

    tmm_xform_if  xform ();
    tmm_matrix_if matrix ();

    matrix_t expected_matrices[$];

    trs_model_matrix_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .xform  (xform),
        .matrix (matrix)
    );

    localparam longint FULL_TURN    = longint'(360) << FRAC_BITS;
    localparam longint QUARTER_TURN = longint'(90) << FRAC_BITS;
    localparam longint DEG_TO_RAD   = 64'd1199381129;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("** trs_model_matrix_top: FAILED **");
        $finish;
    end

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 8, 4, 2};
        return tbl[i];
    endfunction

    task automatic angle_sincos(input logic signed [31:0] deg, output longint c,
                                output longint s);
        longint r, q, d, x, y, z, xn;
        r = longint'(deg) % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        q = r / QUARTER_TURN;
        d = r - q * QUARTER_TURN;
        z = longint'((d * DEG_TO_RAD + (longint'(1) << (FRAC_BITS + 5))) >> (FRAC_BITS + 6));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_entry(i);
            end
            else
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_entry(i);
            end
            x = xn;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_matrix(input xform_t t, output matrix_t m);
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        longint rot[9];
        longint k;
        angle_sincos(t.rot_x_deg, cx, sx);
        angle_sincos(t.rot_y_deg, cy, sy);
        angle_sincos(t.rot_z_deg, cz, sz);
        czsy = q30_mul(cz, sy);
        szsy = q30_mul(sz, sy);
        rot[0] = q30_mul(cz, cy);
        rot[1] = q30_mul(sz, cy);
        rot[2] = -sy;
        rot[3] = q30_mul(czsy, sx) - q30_mul(sz, cx);
        rot[4] = q30_mul(szsy, sx) + q30_mul(cz, cx);
        rot[5] = q30_mul(cy, sx);
        rot[6] = q30_mul(czsy, cx) + q30_mul(sz, sx);
        rot[7] = q30_mul(szsy, cx) - q30_mul(cz, sx);
        rot[8] = q30_mul(cy, cx);
        for (int j = 0; j < 9; j++)
        begin
            k = (j < 3) ? longint'(t.scale_x) : ((j < 6) ? longint'(t.scale_y)
                : longint'(t.scale_z));
            rot[j] = q30_mul(rot[j], k);
        end
        m.m_r0c0  = clamp32(rot[0]);
        m.m_r1c0  = clamp32(rot[1]);
        m.m_r2c0  = clamp32(rot[2]);
        m.m_r0c1  = clamp32(rot[3]);
        m.m_r1c1  = clamp32(rot[4]);
        m.m_r2c1  = clamp32(rot[5]);
        m.m_r0c2  = clamp32(rot[6]);
        m.m_r1c2  = clamp32(rot[7]);
        m.m_r2c2  = clamp32(rot[8]);
        m.trans_x = t.pos_x;
        m.trans_y = t.pos_y;
        m.trans_z = t.pos_z;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one request, predicting its matrix when it is accepted
    task automatic send_xform(input xform_t t);
        matrix_t m;
        int gap;
        gap = gap_cycles();
        if (sent_count % 200 >= 150)
            gap = 0;
        if (gap > 0)
        begin
            xform.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        xform.valid <= 1'b1;
        xform.data  <= t;
        @(posedge clk);
        while (!xform.ready)
            @(posedge clk);
        predict_matrix(t, m);
        expected_matrices.push_back(m);
        sent_count++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            3: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        logic [31:0] a;
        case ($urandom_range(0, 3))
            0: a = ($urandom_range(0, 8) * 45) << 16;
            1: a = $urandom_range(0, 720 * 65536);
            default: a = $urandom;
        endcase
        if ($urandom_range(0, 1))
            a = -a;
        return a;
    endfunction

    function automatic logic [31:0] rand_scale();
        if ($urandom_range(0, 3) == 0)
            return rand_word();
        return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endfunction

    function automatic xform_t make_xform(logic [31:0] ax, logic [31:0] ay,
                                          logic [31:0] az, logic [31:0] k);
        xform_t t;
        t.pos_x = rand_word();
        t.pos_y = rand_word();
        t.pos_z = rand_word();
        t.rot_x_deg = ax;
        t.rot_y_deg = ay;
        t.rot_z_deg = az;
        t.scale_x = k;
        t.scale_y = k;
        t.scale_z = k;
        return t;
    endfunction

    task automatic test_identity_and_quadrants();
        logic [31:0] deg[10] = '{0, 90 << 16, 180 << 16, 270 << 16, 360 << 16,
            45 << 16, -(90 << 16), -(360 << 16), 1, -1};
        for (int i = 0; i < 10; i++)
            send_xform(make_xform(deg[i], deg[(i + 3) % 10], deg[(i + 7) % 10], 32'h00010000));
    endtask

    task automatic test_field_extremes();
        xform_t t;
        logic [31:0] ext[4] = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff};
        for (int i = 0; i < 4; i++)
        begin
            t = make_xform(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i]);
            t.pos_x = ext[i];
            t.pos_y = ext[(i + 1) % 4];
            t.pos_z = ext[(i + 2) % 4];
            send_xform(t);
        end
    endtask

    // large scales drive entries past the signed range
    task automatic test_saturation();
        send_xform(make_xform(0, 0, 0, 32'h7fffffff));
        send_xform(make_xform(180 << 16, 0, 0, 32'h7fffffff));
        send_xform(make_xform(0, 180 << 16, 0, 32'h80000000));
        send_xform(make_xform(45 << 16, 45 << 16, 45 << 16, 32'h80000000));
    endtask

    task automatic test_random_stream();
        xform_t t;
        for (int i = 0; i < 1300; i++)
        begin
            t = make_xform(rand_angle(), rand_angle(), rand_angle(), rand_scale());
            t.scale_y = rand_scale();
            t.scale_z = rand_scale();
            send_xform(t);
        end
    endtask

    // result checker with random backpressure
    initial
    begin
        matrix_t want;
        int stall;
        matrix.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = gap_cycles();
            matrix.ready <= (stall == 0);
            @(posedge clk);
            if (matrix.valid && matrix.ready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    n_errors++;
                    $display("matrix request with nothing expected at %0t", $time);
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    if (matrix.data.m_r0c0 !== want.m_r0c0)
                        report_mismatch("m_r0c0", matrix.data.m_r0c0, want.m_r0c0);
                    if (matrix.data.m_r1c0 !== want.m_r1c0)
                        report_mismatch("m_r1c0", matrix.data.m_r1c0, want.m_r1c0);
                    if (matrix.data.m_r2c0 !== want.m_r2c0)
                        report_mismatch("m_r2c0", matrix.data.m_r2c0, want.m_r2c0);
                    if (matrix.data.m_r0c1 !== want.m_r0c1)
                        report_mismatch("m_r0c1", matrix.data.m_r0c1, want.m_r0c1);
                    if (matrix.data.m_r1c1 !== want.m_r1c1)
                        report_mismatch("m_r1c1", matrix.data.m_r1c1, want.m_r1c1);
                    if (matrix.data.m_r2c1 !== want.m_r2c1)
                        report_mismatch("m_r2c1", matrix.data.m_r2c1, want.m_r2c1);
                    if (matrix.data.m_r0c2 !== want.m_r0c2)
                        report_mismatch("m_r0c2", matrix.data.m_r0c2, want.m_r0c2);
                    if (matrix.data.m_r1c2 !== want.m_r1c2)
                        report_mismatch("m_r1c2", matrix.data.m_r1c2, want.m_r1c2);
                    if (matrix.data.m_r2c2 !== want.m_r2c2)
                        report_mismatch("m_r2c2", matrix.data.m_r2c2, want.m_r2c2);
                    if (matrix.data.trans_x !== want.trans_x)
                        report_mismatch("trans_x", matrix.data.trans_x, want.trans_x);
                    if (matrix.data.trans_y !== want.trans_y)
                        report_mismatch("trans_y", matrix.data.trans_y, want.trans_y);
                    if (matrix.data.trans_z !== want.trans_z)
                        report_mismatch("trans_z", matrix.data.trans_z, want.trans_z);
                end
            end
            if (stall > 1)
                repeat (stall - 1) @(posedge clk);
        end
    end

    initial
    begin
        int waited;
        n_errors     = 0;
        sent_count   = 0;
        rst_n       <= 1'b0;
        xform.valid <= 1'b0;
        xform.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_and_quadrants();
        test_field_extremes();
        test_saturation();
        test_random_stream();
        xform.valid <= 1'b0;
        waited = 0;
        while (expected_matrices.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (n_errors == 0 && expected_matrices.size() == 0)
            $display("** trs_model_matrix_top: PASSED **");
        else
            $display("** trs_model_matrix_top: FAILED **");
        $finish;
    end

endmodule
